// ----- src/pgdr_pkg.sv -----
// Package: shared types, register indexes and constants for the PCM requantizer.
package pgdr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned KnobW   = 4;
  localparam int unsigned CodeW   = 12;
  localparam int unsigned ErrW    = 8;
  localparam int unsigned SeedW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [SeedW-1:0]   SeedReset     = 32'h2545F491;
  localparam logic [GainW-1:0]   HostGainReset = 16'd32767;
  localparam logic [KnobW-1:0]   KnobReset     = 4'd15;
  localparam logic [CodeW-1:0]   CodeMax       = 12'd4095;
  localparam logic signed [ErrW-1:0] ErrLimit  = 8'sd64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOST_GAIN     = 2'd0,
    REG_KNOB_LEVEL    = 2'd1,
    REG_DEVICE_MUTE   = 2'd2,
    REG_STREAM_ACTIVE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GainW-1:0] host_gain;
    logic [KnobW-1:0] knob_level;
    logic             device_mute;
    logic             stream_active;
  } cfg_t;

  // Q15 gain per knob step, 2 dB apart
  function automatic logic [14:0] knob_gain(input logic [KnobW-1:0] lvl);
    logic [14:0] g;
    case (lvl)
      4'd0:    g = 15'd1036;
      4'd1:    g = 15'd1304;
      4'd2:    g = 15'd1642;
      4'd3:    g = 15'd2067;
      4'd4:    g = 15'd2603;
      4'd5:    g = 15'd3277;
      4'd6:    g = 15'd4125;
      4'd7:    g = 15'd5193;
      4'd8:    g = 15'd6538;
      4'd9:    g = 15'd8231;
      4'd10:   g = 15'd10362;
      4'd11:   g = 15'd13045;
      4'd12:   g = 15'd16423;
      4'd13:   g = 15'd20675;
      4'd14:   g = 15'd26029;
      default: g = 15'd32767;
    endcase
    return g;
  endfunction

endpackage

// ----- src/pgdr_if.sv -----
// Interfaces: sample input channel and DAC result channel.
interface pgdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               packet_end;

  modport source (output valid, output pcm_sample, output packet_end, input ready);
  modport sink   (input valid, input pcm_sample, input packet_end, output ready);
endinterface

interface pgdr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] dac_code;
  logic        packet_done;
  logic        signal_present;

  modport source (output valid, output dac_code, output packet_done,
                  output signal_present, input ready);
  modport sink   (input valid, input dac_code, input packet_done,
                  input signal_present, output ready);
endinterface

// ----- src/pgdr_cfg.sv -----
// Configuration register file: host gain, knob level, mute, stream enable.
module pgdr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pgdr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pgdr_pkg::CfgW-1:0]     cfg_wdata,
  output pgdr_pkg::cfg_t                cfg
);
  import pgdr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.host_gain     <= HostGainReset;
      cfg_r.knob_level    <= KnobReset;
      cfg_r.device_mute   <= 1'b0;
      cfg_r.stream_active <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_HOST_GAIN:     cfg_r.host_gain     <= cfg_wdata;
        REG_KNOB_LEVEL:    cfg_r.knob_level    <= cfg_wdata[KnobW-1:0];
        REG_DEVICE_MUTE:   cfg_r.device_mute   <= cfg_wdata[0];
        REG_STREAM_ACTIVE: cfg_r.stream_active <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pgdr_core.sv -----
// Requantizer datapath: gain multiply, error feedback, TPDF dither, round and clamp.
module pgdr_core (
  input  logic signed [pgdr_pkg::SampleW-1:0] sample,
  input  logic        [pgdr_pkg::GainW-1:0]   gain,
  input  logic signed [pgdr_pkg::ErrW-1:0]    err,
  input  logic        [pgdr_pkg::SeedW-1:0]   seed,
  output logic        [pgdr_pkg::CodeW-1:0]   code,
  output logic signed [pgdr_pkg::ErrW-1:0]    err_nxt,
  output logic        [pgdr_pkg::SeedW-1:0]   seed_nxt,
  output logic                                loud
);
  import pgdr_pkg::*;

  logic signed [16:0] gain_s;
  logic signed [32:0] prod;
  logic signed [17:0] scaled;
  logic signed [20:0] x;
  logic signed [20:0] y;
  logic signed [16:0] v;
  logic signed [20:0] e;
  logic [31:0] r1, r2, r3;
  logic [4:0]  dsum;
  logic signed [5:0] dith;

  assign gain_s = $signed({1'b0, gain});
  assign prod   = sample * gain_s;
  assign scaled = prod[32:15];
  assign loud   = (scaled >= 18'sd32) || (scaled <= -18'sd32);

  assign r1 = seed ^ (seed << 13);
  assign r2 = r1 ^ (r1 >> 17);
  assign r3 = r2 ^ (r2 << 5);
  assign seed_nxt = r3;

  assign dsum = {1'b0, r3[3:0]} + {1'b0, r3[7:4]};
  assign dith = $signed({1'b0, dsum}) - 6'sd15;

  assign x = 21'(scaled) + 21'sd32768 + 21'(err);
  assign y = x + 21'(dith) + 21'sd8;
  assign v = y[20:4];

  always_comb begin
    if (v < 17'sd0) begin
      code = '0;
    end else if (v > $signed({5'b0, CodeMax})) begin
      code = CodeMax;
    end else begin
      code = v[CodeW-1:0];
    end
  end

  assign e = x - $signed({5'b0, code, 4'b0});

  always_comb begin
    if (e > 21'(ErrLimit)) begin
      err_nxt = ErrLimit;
    end else if (e < -21'(ErrLimit)) begin
      err_nxt = -ErrLimit;
    end else begin
      err_nxt = e[ErrW-1:0];
    end
  end

endmodule

// ----- src/pcm_gain_dither_requantizer_top.sv -----
// Top level: PCM gain, dither and requantizer to a 12-bit DAC code.
//
// Samples enter on in_ch (valid/ready), each with a packet_end mark. Results
// leave on out_ch: dac_code, packet_done, and signal_present at packet end.
// Registers (0 host_gain, 1 knob_level, 2 device_mute, 3 stream_active) are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while idle, which the block does not enforce. One item is taken per cycle
// unless the output stalls: the input stage forms the effective gain (host
// gain times knob table, zero when muted), the second stage does the sample
// multiply, error feedback, dither and rounding, and loads the output
// register, which drives out_ch.valid, together with the state.
// While stream_active is 0 items are taken and dropped with no result.
// If the receiver stalls, the result is held; the input stage keeps one more
// item, then in_ch.ready drops until the output register empties.
// Reset sets the valid, state and config registers: seed 0x2545F491,
// zero error feedback, host gain 32767, knob 15, unmuted, stream inactive.
module pcm_gain_dither_requantizer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  pgdr_in_if.sink                       in_ch,
  pgdr_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [pgdr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pgdr_pkg::CfgW-1:0]     cfg_wdata
);
  import pgdr_pkg::*;

  cfg_t cfg;

  logic                      s1_v_r;
  logic signed [SampleW-1:0] s1_sample_r;
  logic                      s1_last_r;
  logic [GainW-1:0]          s1_gain_r;
  logic                      s1_act_r;

  logic             out_v_r;
  logic [CodeW-1:0] out_code_r;
  logic             out_done_r;
  logic             out_pres_r;

  logic [SeedW-1:0]         seed_r;
  logic signed [ErrW-1:0]   err_r;
  logic                     loud_r;

  logic [30:0]             gprod;
  logic [GainW-1:0]        gain_in;
  logic                    in_acc;
  logic                    s1_adv;
  logic [CodeW-1:0]        code;
  logic signed [ErrW-1:0]  err_nxt;
  logic [SeedW-1:0]        seed_nxt;
  logic                    loud;
  logic                    loud_any;

  pgdr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pgdr_core u_core (
    .sample   (s1_sample_r),
    .gain     (s1_gain_r),
    .err      (err_r),
    .seed     (seed_r),
    .code     (code),
    .err_nxt  (err_nxt),
    .seed_nxt (seed_nxt),
    .loud     (loud)
  );

  assign gprod   = {15'b0, cfg.host_gain} * {16'b0, knob_gain(cfg.knob_level)};
  assign gain_in = cfg.device_mute ? '0 : gprod[30:15];

  assign s1_adv      = s1_v_r && (!s1_act_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign loud_any    = loud_r || loud;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.pcm_sample;
      s1_last_r   <= in_ch.packet_end;
      s1_gain_r   <= gain_in;
      s1_act_r    <= cfg.stream_active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      seed_r  <= SeedReset;
      err_r   <= '0;
      loud_r  <= 1'b0;
    end else begin
      if (s1_adv && s1_act_r) begin
        out_v_r <= 1'b1;
        seed_r  <= seed_nxt;
        err_r   <= err_nxt;
        loud_r  <= s1_last_r ? 1'b0 : loud_any;
      end else begin
        if (out_ch.ready) begin
          out_v_r <= 1'b0;
        end
        if (s1_adv && s1_last_r) begin
          loud_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_act_r) begin
      out_code_r <= code;
      out_done_r <= s1_last_r;
      out_pres_r <= s1_last_r && loud_any;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.dac_code       = out_code_r;
  assign out_ch.packet_done    = out_done_r;
  assign out_ch.signal_present = out_pres_r;

`ifndef SYNTHESIS
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r <= ErrLimit) && (err_r >= -ErrLimit))
    else $error("error feedback out of range");

  a_seed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    seed_r != '0)
    else $error("dither seed reached zero");

  a_present_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_pres_r |-> out_done_r)
    else $error("signal_present outside packet end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !(s1_adv && s1_act_r))
    else $error("stalled result overwritten");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_act_r) |=> $stable(seed_r) && $stable(err_r))
    else $error("state changed without an active item");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the PCM gain, dither and 12-bit requantizer block.
module tb_top;
  import pgdr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int KnobQ15 [16] = '{1036, 1304, 1642, 2067, 2603, 3277, 4125, 5193,
                                  6538, 8231, 10362, 13045, 16423, 20675, 26029, 32767};

  typedef struct {
    logic [CodeW-1:0] code;
    logic             done;
    logic             present;
  } dac_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_wdata;

  pgdr_in_if  in_ch();
  pgdr_out_if out_ch();

  cfg_t            reg_shadow;
  logic [SeedW-1:0] dither_lfsr;
  int              err_carry;
  bit              loud_flag;
  dac_result_t     dac_expect_q [$];
  dac_result_t     want;
  int              err_cnt;
  int              cycle_cnt;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              rx_hold_cycles;

  pcm_gain_dither_requantizer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic flag(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // expected DAC result for one accepted sample; none while the stream is inactive
  task automatic requantize_sample(input logic signed [15:0] smp, input logic last);
    longint gain, scaled, mag, biased, code, resid;
    logic [31:0] r;
    int dith;
    dac_result_t res;
    if (!reg_shadow.stream_active) begin
      if (last) loud_flag = 1'b0;
      return;
    end
    gain = reg_shadow.device_mute ? 0 :
           ((longint'(reg_shadow.host_gain) * KnobQ15[reg_shadow.knob_level]) >>> 15);
    scaled = (longint'(smp) * gain) >>> 15;
    mag = (scaled < 0) ? -scaled : scaled;
    if (mag >= 32) loud_flag = 1'b1;
    biased = scaled + 32768 + err_carry;
    r = dither_lfsr;
    r ^= r << 13;
    r ^= r >> 17;
    r ^= r << 5;
    dither_lfsr = r;
    dith = int'(r[3:0]) + int'(r[7:4]) - 15;
    code = (biased + dith + 8) >>> 4;
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    resid = biased - code * 16;
    if (resid > 64) resid = 64;
    else if (resid < -64) resid = -64;
    err_carry = int'(resid);
    res.code = code[CodeW-1:0];
    res.done = last;
    res.present = last ? loud_flag : 1'b0;
    if (last) loud_flag = 1'b0;
    dac_expect_q.push_back(res);
  endtask

  function automatic int tx_gap();
    if ($urandom_range(99) < tx_idle_pct) return $urandom_range(3, 1);
    return 0;
  endfunction

  task automatic send_sample(input logic signed [15:0] smp, input logic last,
                             input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pcm_sample <= smp;
    in_ch.packet_end <= last;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    requantize_sample(smp, last);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dac_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_HOST_GAIN:     reg_shadow.host_gain = data;
      REG_KNOB_LEVEL:    reg_shadow.knob_level = data[KnobW-1:0];
      REG_DEVICE_MUTE:   reg_shadow.device_mute = data[0];
      REG_STREAM_ACTIVE: reg_shadow.stream_active = data[0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk to check masking
  task automatic apply_regs(input logic [15:0] hg, input logic [3:0] kn,
                            input bit mu, input bit act);
    logic [15:0] junk;
    drain();
    junk = 16'($urandom);
    write_reg(REG_HOST_GAIN, hg);
    write_reg(REG_KNOB_LEVEL, {junk[15:4], kn});
    write_reg(REG_DEVICE_MUTE, {junk[15:1], mu});
    write_reg(REG_STREAM_ACTIVE, {junk[14:0], act});
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6:    return 16'(int'($urandom_range(127)) - 64);
      7:          return 16'sh7FFF;
      8:          return 16'sh8000;
      default:    return $urandom_range(1) ? 16'(int'($urandom_range(40, 25)))
                                           : 16'(-int'($urandom_range(40, 25)));
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dac_expect_q.size() == 0) begin
        flag($sformatf("unexpected result code=%0d", out_ch.dac_code));
      end else begin
        want = dac_expect_q.pop_front();
        if (out_ch.dac_code !== want.code)
          flag($sformatf("dac_code got %0d want %0d", out_ch.dac_code, want.code));
        if (out_ch.packet_done !== want.done)
          flag($sformatf("packet_done got %b want %b", out_ch.packet_done, want.done));
        if (out_ch.signal_present !== want.present)
          flag($sformatf("signal_present got %b want %b",
                         out_ch.signal_present, want.present));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic do_reset();
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    reg_shadow.host_gain     = HostGainReset;
    reg_shadow.knob_level    = KnobReset;
    reg_shadow.device_mute   = 1'b0;
    reg_shadow.stream_active = 1'b0;
    dither_lfsr = SeedReset;
    err_carry   = 0;
    loud_flag   = 1'b0;
    @(posedge clk);
  endtask

  // dropped while inactive, then reset gain with only the stream enabled
  task automatic test_reset_gain();
    send_sample(16'sd12000, 1'b0, 0);
    send_sample(-16'sd9000, 1'b1, 1);
    send_sample(16'sd5, 1'b0, 0);
    drain();
    write_reg(REG_STREAM_ACTIVE, 16'd1);
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF, 1'b0, 0);
    send_sample(16'sh8000, 1'b0, 0);
    send_sample(16'sd0, 1'b0, 0);
    send_sample(-16'sd1, 1'b1, 0);
    send_sample(16'sd32, 1'b1, 0);
    send_sample(16'sd33, 1'b1, 0);
    send_sample(-16'sd32, 1'b1, 0);
    send_sample(16'sd31, 1'b1, 0);
  endtask

  task automatic test_gain_extremes();
    apply_regs(16'hFFFF, 4'd15, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b0, 0);
    send_sample(16'sh8000, 1'b0, 0);
    send_sample(16'sd1000, 1'b0, 0);
    send_sample(-16'sd1000, 1'b1, 0);
    apply_regs(16'h0000, 4'd0, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b0, 0);
    send_sample(16'sh8000, 1'b1, 0);
    apply_regs(16'hFFFF, 4'd0, 1'b0, 1'b1);
    send_sample(16'sd12345, 1'b1, 0);
  endtask

  task automatic test_mute();
    apply_regs(16'hFFFF, 4'd15, 1'b1, 1'b1);
    send_sample(16'sh7FFF, 1'b1, 0);
    send_sample(16'sh8000, 1'b0, 0);
    send_sample(16'sd100, 1'b1, 0);
  endtask

  // a dropped packet end must clear the loud mark
  task automatic test_dropped_framing();
    apply_regs(16'h7FFF, 4'd15, 1'b0, 1'b1);
    send_sample(16'sd20000, 1'b0, 0);
    apply_regs(16'h7FFF, 4'd15, 1'b0, 1'b0);
    send_sample(16'sd5, 1'b1, 0);
    send_sample(16'sd7, 1'b0, 0);
    apply_regs(16'h7FFF, 4'd15, 1'b0, 1'b1);
    send_sample(16'sd3, 1'b1, 0);
  endtask

  task automatic test_random_packets(input int n_items, input int idle_pct);
    int sent, phase_len, len, i;
    logic [15:0] hg;
    logic last;
    sent = 0;
    tx_idle_pct = idle_pct;
    rx_idle_pct = idle_pct;
    while (sent < n_items) begin
      case ($urandom_range(5))
        0:       hg = 16'h0000;
        1:       hg = 16'hFFFF;
        2:       hg = 16'h7FFF;
        default: hg = 16'($urandom);
      endcase
      apply_regs(hg, 4'($urandom_range(15)), $urandom_range(99) < 15,
                 $urandom_range(99) >= 10);
      phase_len = $urandom_range(80, 30);
      while (phase_len > 0) begin
        len = $urandom_range(12, 1);
        for (i = 0; i < len; i++) begin
          last = (i == len - 1);
          if ($urandom_range(99) < 5) last = $urandom_range(1);
          send_sample(rand_sample(), last, tx_gap());
          if (reg_shadow.stream_active) sent++;
        end
        phase_len -= len;
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    apply_regs(16'($urandom), 4'($urandom_range(15)), 1'b0, 1'b1);
    rx_hold_cycles = 200;
    for (i = 0; i < 40; i++)
      send_sample(rand_sample(), $urandom_range(3) == 0, 0);
    drain();
    for (i = 0; i < 20; i++)
      send_sample(rand_sample(), $urandom_range(3) == 0, tx_gap());
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.pcm_sample = '0;
    in_ch.packet_end = 1'b0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    tx_idle_pct      = 30;
    rx_idle_pct      = 30;
    rx_hold_cycles   = 0;
    do_reset();
    test_reset_gain();
    test_gain_extremes();
    test_mute();
    test_dropped_framing();
    test_random_packets(580, 30);
    test_backpressure();
    test_random_packets(120, 0);
    drain();
    if (dac_expect_q.size() != 0)
      flag($sformatf("%0d results never arrived", dac_expect_q.size()));
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pgdr_pkg.sv
src/pgdr_if.sv
src/pgdr_cfg.sv
src/pgdr_core.sv
src/pcm_gain_dither_requantizer_top.sv
sim/tb_top.sv
